// File: src/expag_pkg.sv
// Shared constants, table builders and types for the exponential adaptive gain block
package expag_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_ADDR_W      = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_TERMS       = 12;

  localparam int NORM_W     = 24;
  localparam int WORD_W     = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_SCALE_TERM  = 2'd0;
  localparam logic [1:0] REG_DECAY_RATE  = 2'd1;
  localparam logic [1:0] REG_OFFSET_TERM = 2'd2;

  localparam logic [WORD_W-1:0] SCALE_TERM_RST  = 32'd98265;
  localparam logic [WORD_W-1:0] DECAY_RATE_RST  = 32'd72818;
  localparam logic [WORD_W-1:0] OFFSET_TERM_RST = 32'd10918;

  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam logic [26:0]     LOG2E_Q24 = 27'd24204406;

  localparam int Y_W   = 2 * FRAC_BITS + 8;
  localparam int Y_SHR = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int Y_SHL = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;

  typedef logic [EXP_TABLE_DEPTH-1:0][31:0] exp_rom_t;

  function automatic longint unsigned exp_entry(input int unsigned i);
    longint unsigned z;
    longint unsigned term;
    longint unsigned sum;
    z    = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int n = 1; n <= EXP_TERMS; n++) begin
      term = (term * z) >> 30;
      term = term / 64'(n);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic exp_rom_t build_exp_base();
    exp_rom_t rom;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = 32'(exp_entry(i));
    end
    return rom;
  endfunction

  function automatic exp_rom_t build_exp_step();
    exp_rom_t rom;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = 32'(exp_entry(i + 1) - exp_entry(i));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_BASE = build_exp_base();
  localparam exp_rom_t EXP_STEP = build_exp_step();

endpackage

// File: src/expag_if.sv
// Request channels for error norms in and gains out
interface expag_norm_if
  import expag_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NORM_W-1:0] error_norm;

  modport source (output valid, output error_norm, input ready);
  modport sink   (input valid, input error_norm, output ready);
endinterface

interface expag_gain_if
  import expag_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] gain_value;
  logic signed [WORD_W-1:0] limit_gain;
  logic                     saturated;

  modport source (output valid, output gain_value, output limit_gain, output saturated,
                  input ready);
  modport sink   (input valid, input gain_value, input limit_gain, input saturated,
                  output ready);
endinterface

// File: src/exponential_adaptive_gain_core.sv
// Pipelined gain evaluator a*exp(-b*x)+c with APB coefficient registers
//
//   channel | direction | carries
//   norm    | in        | error_norm (unsigned Q8.16)
//   gain    | out       | gain_value, limit_gain (signed Q16.16), saturated
//   apb     | in/out    | scale_term, decay_rate, offset_term at 0x0, 0x4, 0x8
//
// Ten register stages hold the three multiplies, the table interpolation and
// the shift-round-saturate chain; one request enters per cycle unless a full
// pipeline is stalled by gain.ready. Synchronous reset clears valid bits and
// restores the coefficients. Each stage holds while its successor is full and
// stalled, so bubbles close up and nothing is dropped or repeated.
module exponential_adaptive_gain_core
  import expag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  expag_norm_if.sink            norm,
  expag_gain_if.source          gain,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]     pwdata,
  output logic [WORD_W-1:0]     prdata,
  output logic                  pready
);

  localparam int NSTAGE = 10;

  typedef enum logic [1:0] {TERM_ZERO, TERM_RIGHT, TERM_LEFT, TERM_SAT} term_mode_t;

  localparam logic signed [56:0] YLIM     = 57'sd1 <<< (2 * FRAC_BITS + 6);
  localparam logic signed [63:0] TERM_CAP = 64'sd1 <<< 40;
  localparam logic signed [64:0] INT_MAX  = 65'sd2147483647;
  localparam logic signed [64:0] INT_MIN  = -65'sd2147483648;

  logic [WORD_W-1:0] scale_term;
  logic [WORD_W-1:0] decay_rate;
  logic [WORD_W-1:0] offset_term;

  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] en;

  logic signed [56:0]         s1_prod;
  logic signed [Y_W-1:0]      s2_y;
  logic signed [63:0]         s3_wp;
  logic [31:0]                s4_base;
  logic [31:0]                s4_step;
  logic [29:0]                s4_r;
  logic signed [9:0]          s4_k;
  logic [61:0]                s5_ip;
  logic [31:0]                s5_base;
  logic signed [9:0]          s5_k;
  logic [31:0]                s6_m;
  logic signed [9:0]          s6_k;
  logic signed [63:0]         s7_p;
  logic signed [9:0]          s7_k;
  term_mode_t                 s8_mode;
  logic [5:0]                 s8_amt;
  logic signed [64:0]         s8_val;
  logic                       s8_neg;
  logic signed [63:0]         s9_term;
  logic signed [WORD_W-1:0]   s10_gain;
  logic signed [WORD_W-1:0]   s10_limit;
  logic                       s10_sat;

  logic signed [56:0] neg_prod;
  logic signed [63:0] y_wide;
  logic signed [63:0] y30_wide;
  logic signed [37:0] y30;
  logic [29:0]        frac;
  logic [EXP_ADDR_W-1:0] idx;
  logic signed [64:0] wp_full;
  logic signed [64:0] p_full;
  logic signed [10:0] shv;
  logic signed [10:0] slv;
  logic [63:0]        mag;
  logic [40:0]        cap_lim;
  logic signed [64:0] p_ext;
  logic signed [64:0] p_round;
  term_mode_t         mode_next;
  logic [5:0]         amt_next;
  logic signed [64:0] val_next;
  logic signed [63:0] term_next;
  logic signed [64:0] sum;

  // APB registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_term  <= SCALE_TERM_RST;
      decay_rate  <= DECAY_RATE_RST;
      offset_term <= OFFSET_TERM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SCALE_TERM:  scale_term  <= pwdata;
        REG_DECAY_RATE:  decay_rate  <= pwdata;
        REG_OFFSET_TERM: offset_term <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE_TERM:  prdata = scale_term;
      REG_DECAY_RATE:  prdata = decay_rate;
      REG_OFFSET_TERM: prdata = offset_term;
      default:         prdata = '0;
    endcase
  end

  // stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || gain.ready;
    for (int s = NSTAGE - 1; s >= 1; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign norm.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = NSTAGE; s >= 2; s--) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
      if (en[1]) begin
        vld[1] <= norm.valid;
      end
    end
  end

  // datapath combinational parts
  always_comb begin
    neg_prod = -s1_prod;
    y_wide   = 64'(s2_y);
    y30_wide = (y_wide >>> Y_SHR) <<< Y_SHL;
    y30      = y30_wide[37:0];
    wp_full  = 65'(y30) * 65'($signed({1'b0, LOG2E_Q24}));
    frac     = s3_wp[53:24];
    idx      = frac[29 -: EXP_ADDR_W];
    p_full   = 65'($signed(scale_term)) * 65'($signed({1'b0, s6_m}));
  end

  always_comb begin
    shv     = 11'sd30 - 11'(s7_k);
    slv     = -shv;
    p_ext   = 65'(s7_p);
    mag     = s7_p[63] ? 64'(-s7_p) : 64'(s7_p);
    cap_lim = 41'(TERM_CAP) >> slv[5:0];
    p_round = p_ext;
    if (shv > 11'sd0 && shv <= 11'sd62) begin
      p_round = p_ext + (65'sd1 <<< (shv[5:0] - 6'd1));
    end
    amt_next = '0;
    val_next = p_ext;
    if (s7_p == 64'sd0) begin
      mode_next = TERM_ZERO;
    end else if (shv >= 11'sd0) begin
      if (shv > 11'sd62) begin
        mode_next = TERM_ZERO;
      end else begin
        mode_next = TERM_RIGHT;
        amt_next  = shv[5:0];
        val_next  = p_round;
      end
    end else if (slv >= 11'sd40 || mag > 64'(cap_lim)) begin
      mode_next = TERM_SAT;
    end else begin
      mode_next = TERM_LEFT;
      amt_next  = slv[5:0];
    end
  end

  always_comb begin
    case (s8_mode)
      TERM_RIGHT: term_next = 64'(s8_val >>> s8_amt);
      TERM_LEFT:  term_next = s8_val[63:0] <<< s8_amt;
      TERM_SAT:   term_next = s8_neg ? -TERM_CAP : TERM_CAP;
      default:    term_next = '0;
    endcase
    sum = 65'(s9_term) + 65'($signed(offset_term));
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod <= 57'($signed(decay_rate)) * 57'($signed({1'b0, norm.error_norm}));
    end
    if (en[2]) begin
      if (neg_prod > YLIM) begin
        s2_y <= Y_W'(YLIM);
      end else if (neg_prod < -YLIM) begin
        s2_y <= Y_W'(-YLIM);
      end else begin
        s2_y <= Y_W'(neg_prod);
      end
    end
    if (en[3]) begin
      s3_wp <= wp_full[63:0];
    end
    if (en[4]) begin
      s4_base <= EXP_BASE[idx];
      s4_step <= EXP_STEP[idx];
      s4_r    <= frac << EXP_ADDR_W;
      s4_k    <= s3_wp[63:54];
    end
    if (en[5]) begin
      s5_ip   <= 62'(s4_step[29:0]) * 62'(s4_r) +
                 ((62'(s4_step[31:30]) * 62'(s4_r)) << 30);
      s5_base <= s4_base;
      s5_k    <= s4_k;
    end
    if (en[6]) begin
      s6_m <= s5_base + s5_ip[61:30];
      s6_k <= s5_k;
    end
    if (en[7]) begin
      s7_p <= p_full[63:0];
      s7_k <= s6_k;
    end
    if (en[8]) begin
      s8_mode <= mode_next;
      s8_amt  <= amt_next;
      s8_val  <= val_next;
      s8_neg  <= s7_p[63];
    end
    if (en[9]) begin
      s9_term <= term_next;
    end
    if (en[10]) begin
      s10_limit <= $signed(offset_term);
      if (sum > INT_MAX) begin
        s10_gain <= WORD_W'(INT_MAX);
        s10_sat  <= 1'b1;
      end else if (sum < INT_MIN) begin
        s10_gain <= WORD_W'(INT_MIN);
        s10_sat  <= 1'b1;
      end else begin
        s10_gain <= WORD_W'(sum);
        s10_sat  <= 1'b0;
      end
    end
  end

  assign gain.valid      = vld[NSTAGE];
  assign gain.gain_value = s10_gain;
  assign gain.limit_gain = s10_limit;
  assign gain.saturated  = s10_sat;

endmodule

// File: sim/exponential_adaptive_gain_core_test.sv
// Self-checking testbench for exponential_adaptive_gain_core: directed table, then random phases
module exponential_adaptive_gain_core_test
  import expag_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 8;
  localparam int PIPE_LATENCY  = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int CALM_PHASE    = 2;
  localparam int PLAN_ROWS     = 32;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam longint     Q30_MASK     = (64'sd1 <<< 30) - 1;
  localparam longint     TERM_CAP     = 64'sd1 <<< 40;
  localparam longint     GAIN_MAX     = 64'sd2147483647;
  localparam longint     GAIN_MIN     = -64'sd2147483648;

  typedef enum logic [1:0] {ROW_NORM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        known;
    logic [31:0] gain;
    logic [31:0] limit;
    logic        sat;
  } plan_row_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] gain;
    logic signed [WORD_W-1:0] limit;
    logic                     sat;
  } gain_res_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0000, 1'b1, SCALE_TERM_RST + OFFSET_TERM_RST,
      OFFSET_TERM_RST, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h00FF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0001_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_SCALE_TERM,  32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0012_3456, 1'b1, OFFSET_TERM_RST, OFFSET_TERM_RST, 1'b0},
    '{ROW_WRITE, REG_SCALE_TERM,  32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_DECAY_RATE,  32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h00FF_FFFF, 1'b1, 32'h7FFF_FFFF, OFFSET_TERM_RST, 1'b1},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF, OFFSET_TERM_RST, 1'b1},
    '{ROW_WRITE, REG_SCALE_TERM,  32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h00FF_FFFF, 1'b1, 32'h8000_0000, OFFSET_TERM_RST, 1'b1},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_DECAY_RATE,  32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_OFFSET_TERM, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h00FF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0},
    '{ROW_WRITE, REG_OFFSET_TERM, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h00FF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WRITE, REG_UNMAPPED,    32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WRITE, REG_DECAY_RATE,  32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0080_0000, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WRITE, REG_SCALE_TERM,  SCALE_TERM_RST, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_DECAY_RATE,  -DECAY_RATE_RST, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_OFFSET_TERM, OFFSET_TERM_RST, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0002_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h00FF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_DECAY_RATE,  DECAY_RATE_RST, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0000_0100, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h007F_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{ROW_NORM,  REG_UNMAPPED,    32'h0055_AAAA, 1'b0, 32'h0, 32'h0, 1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [WORD_W-1:0]     pwdata;
  logic [WORD_W-1:0]     prdata;
  logic                  pready;
  logic                  calm;

  logic signed [WORD_W-1:0] scale_q;
  logic signed [WORD_W-1:0] decay_q;
  logic signed [WORD_W-1:0] offset_q;
  longint                   exp_table [0:EXP_TABLE_DEPTH];

  gain_res_t pending_gains [$];
  gain_res_t head_gain;
  int        fail_count;
  int        norms_sent;
  int        directed_norms;
  int        gains_checked;
  int        gains_clipped;
  int        reg_writes;

  expag_norm_if norm_ch ();
  expag_gain_if gain_ch ();

  exponential_adaptive_gain_core uut (
    .clk     (clk),
    .rst     (rst),
    .norm    (norm_ch),
    .gain    (gain_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic gain_res_t predict_gain(input logic [NORM_W-1:0] x);
    gain_res_t res;
    longint    a, b, c, lim, y, y30, w, k, frac, t, idx, r, m, p, term, total, sh;
    a   = longint'(scale_q);
    b   = longint'(decay_q);
    c   = longint'(offset_q);
    lim = 64'sd64 <<< (2 * FRAC_BITS);
    y   = -(b * longint'(x));
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    y30  = (y >>> Y_SHR) <<< Y_SHL;
    w    = (y30 * longint'(LOG2E_Q24)) >>> 24;
    k    = w >>> 30;
    frac = w & Q30_MASK;
    t    = frac * EXP_TABLE_DEPTH;
    idx  = t >>> 30;
    if (idx >= EXP_TABLE_DEPTH) idx = EXP_TABLE_DEPTH - 1;
    r = t & Q30_MASK;
    m = exp_table[idx] + (((exp_table[idx + 1] - exp_table[idx]) * r) >>> 30);
    p = a * m;
    if (p == 0) begin
      term = 0;
    end else if (k <= 30) begin
      sh = 30 - k;
      if (sh == 0) term = p;
      else if (sh > 62) term = 0;
      else term = (p + (64'sd1 <<< (sh - 1))) >>> sh;
    end else begin
      sh = k - 30;
      if (sh >= 40 || (p < 0 ? -p : p) > (TERM_CAP >>> sh)) begin
        term = (p < 0) ? -TERM_CAP : TERM_CAP;
      end else begin
        term = p <<< sh;
      end
    end
    total   = term + c;
    res.sat = 1'b0;
    if (total > GAIN_MAX) begin
      total   = GAIN_MAX;
      res.sat = 1'b1;
    end else if (total < GAIN_MIN) begin
      total   = GAIN_MIN;
      res.sat = 1'b1;
    end
    res.gain  = WORD_W'(total);
    res.limit = WORD_W'(c);
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] coef_pick(input int span);
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom;
      default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endcase
  endfunction

  function automatic logic [NORM_W-1:0] norm_pick();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return NORM_W'($urandom);
      4, 5, 6: return NORM_W'($urandom_range(0, 1 << (FRAC_BITS + 2)));
      default: return NORM_W'($urandom_range(0, 1 << FRAC_BITS));
    endcase
  endfunction

  task automatic drain_gains();
    norm_ch.valid = 1'b0;
    while (pending_gains.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [WORD_W-1:0] wdata, output logic [WORD_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = CFG_ADDR_W'({idx, 2'b00});
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] value);
    logic [WORD_W-1:0] readback;
    drain_gains();
    apb_access(1'b1, idx, value, readback);
    reg_writes++;
    case (idx)
      REG_SCALE_TERM:  scale_q = value;
      REG_DECAY_RATE:  decay_q = value;
      REG_OFFSET_TERM: offset_q = value;
      default: ;
    endcase
    if (idx != REG_UNMAPPED) begin
      apb_access(1'b0, idx, '0, readback);
      if (readback !== value) begin
        $error("prdata: expected %h, got %h", value, readback);
        fail_count++;
      end
    end
  endtask

  task automatic send_norm(input logic [NORM_W-1:0] x, input logic known,
                           input gain_res_t typed_res);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      norm_ch.valid = 1'b0;
      @(negedge clk);
    end
    norm_ch.valid      = 1'b1;
    norm_ch.error_norm = x;
    @(posedge clk);
    while (!norm_ch.ready) @(posedge clk);
    pending_gains.push_back(known ? typed_res : predict_gain(x));
    norms_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    gain_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && gain_ch.valid && gain_ch.ready) begin
      if (pending_gains.size() == 0) begin
        $error("gain result with no request pending: gain_value %0d", gain_ch.gain_value);
        fail_count++;
      end else begin
        head_gain = pending_gains.pop_front();
        gains_checked++;
        if (gain_ch.saturated === 1'b1) gains_clipped++;
        if (gain_ch.gain_value !== head_gain.gain) begin
          $error("gain_value: expected %0d, got %0d", head_gain.gain, gain_ch.gain_value);
          fail_count++;
        end
        if (gain_ch.limit_gain !== head_gain.limit) begin
          $error("limit_gain: expected %0d, got %0d", head_gain.limit, gain_ch.limit_gain);
          fail_count++;
        end
        if (gain_ch.saturated !== head_gain.sat) begin
          $error("saturated: expected %0b, got %0b", head_gain.sat, gain_ch.saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (norm_ch.valid && norm_ch.ready) || (gain_ch.valid && gain_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("exponential_adaptive_gain_core_test failed");
    $finish;
  end

  initial begin
    longint unsigned z, step, acc;
    plan_row_t       row;
    gain_res_t       typed;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      z    = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
      step = 64'd1 << 30;
      acc  = step;
      for (int n = 1; n <= EXP_TERMS; n++) begin
        step = ((step * z) >> 30) / 64'(n);
        acc  = acc + step;
      end
      exp_table[i] = longint'(acc);
    end

    rst                = 1'b1;
    calm               = 1'b0;
    norm_ch.valid      = 1'b0;
    norm_ch.error_norm = '0;
    gain_ch.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    scale_q            = SCALE_TERM_RST;
    decay_q            = DECAY_RATE_RST;
    offset_q           = OFFSET_TERM_RST;
    fail_count         = 0;
    norms_sent         = 0;
    gains_checked      = 0;
    gains_clipped      = 0;
    reg_writes         = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.reg_idx, row.value);
      end else begin
        typed = '{row.gain, row.limit, row.sat};
        send_norm(row.value[NORM_W-1:0], row.known, typed);
      end
    end
    directed_norms = norms_sent;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == CALM_PHASE);
      write_reg(REG_SCALE_TERM, coef_pick(1 << 19));
      write_reg(REG_DECAY_RATE, coef_pick(1 << 17));
      write_reg(REG_OFFSET_TERM, coef_pick(1 << 19));
      repeat (PHASE_ITEMS) send_norm(norm_pick(), 1'b0, '0);
    end
    calm = 1'b0;

    drain_gains();
    repeat (2 * PIPE_LATENCY) @(negedge clk);

    $display("Sent %0d error norms (%0d from the directed table) over %0d coefficient sets,",
             norms_sent, directed_norms, RANDOM_PHASES + 1);
    $display("checked %0d gains, %0d of them clipped, with %0d register writes.",
             gains_checked, gains_clipped, reg_writes);
    if (fail_count == 0) begin
      $display("exponential_adaptive_gain_core_test passed");
    end else begin
      $display("exponential_adaptive_gain_core_test failed");
    end
    $finish;
  end

endmodule
